// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pattern id core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, skipped while aresetn is low.
`define VTPID_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every rising edge of aclk, reset cycles included.
`define VTPID_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// File: rtl/core/vtpid_pkg.sv
// ----------------------------------------------------------------------------
// vtpid_pkg
// Types, constants and helper functions of the voxel track pattern id core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtpid_pkg;

    // Field widths and counts
    localparam int NUM_HITS      = 6;
    localparam int OUT_LAYERS    = 5;
    localparam int COUNT_W       = 3;
    localparam int COPY_W        = 8;
    localparam int COORD_W       = 3;
    localparam int CODE_W        = 5;
    localparam int CHAR_W        = 7;
    localparam int TBL_DEPTH     = 1 << COPY_W;
    localparam int CUBE_SIZE_DEF = 6;

    // Stream data widths, padded to whole bytes
    localparam int S_FIELDS_W = COUNT_W + NUM_HITS * COPY_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + 2 * OUT_LAYERS * CHAR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Code values
    localparam logic [COUNT_W-1:0] MIN_HITS   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] MAX_HITS   = COUNT_W'(NUM_HITS);
    localparam logic [CODE_W-1:0]  EMPTY_CODE = CODE_W'(23);
    localparam logic [CODE_W-1:0]  NEG_BIAS   = CODE_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_BASE = CHAR_W'(97);
    localparam logic [CHAR_W-1:0]  ASCII_LAST = CHAR_W'(120);

    // One hit with its copy number split into layer, row and column
    typedef struct packed {
        logic               beyond;   // slot at or past hit_count
        logic [COPY_W-1:0]  copy;
        logic [COORD_W-1:0] layer;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } hit_t;

    // Request moving through the sorter
    typedef struct packed {
        logic                     bad;
        hit_t [NUM_HITS-1:0]      hit;
    } sort_item_t;

    typedef logic [TBL_DEPTH-1:0][3*COORD_W-1:0] dec_tbl_t;

    // Copy number to {layer, row, col}, built by counting at elaboration
    function automatic dec_tbl_t decomp_table(input int cube);
        dec_tbl_t t;
        int l;
        int r;
        int c;
        l = 0;
        r = 0;
        c = 0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            t[i] = {COORD_W'(l), COORD_W'(r), COORD_W'(c)};
            c = c + 1;
            if (c == cube) begin
                c = 0;
                r = r + 1;
                if (r == cube) begin
                    r = 0;
                    l = l + 1;
                end
            end
        end
        return t;
    endfunction

    // Sort key: slots beyond the count go to the end
    function automatic logic key_le(input hit_t a, input hit_t b);
        return {a.beyond, a.copy} <= {b.beyond, b.copy};
    endfunction

    // Offset from the vertex: plain when not negative, magnitude + 10 otherwise
    function automatic logic [CODE_W-1:0] offset_code(input logic [COORD_W-1:0] v,
                                                      input logic [COORD_W-1:0] ref_v);
        logic [CODE_W-1:0] code;
        if (v >= ref_v) begin
            code = CODE_W'(v - ref_v);
        end else begin
            code = CODE_W'(ref_v - v) + NEG_BIAS;
        end
        return code;
    endfunction

endpackage

// File: rtl/core/vtpid_sort6.sv
// ----------------------------------------------------------------------------
// vtpid_sort6
// Two-stage sorting network for six hits (five comparator layers).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vtpid_sort6 import vtpid_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  sort_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output sort_item_t out_item
);

    logic       a_valid_reg;
    logic       b_valid_reg;
    sort_item_t a_item_reg;
    sort_item_t b_item_reg;
    sort_item_t a_next;
    sort_item_t b_next;
    logic       en_a;
    logic       en_b;

    function automatic hit_t lo(input hit_t x, input hit_t y);
        return key_le(x, y) ? x : y;
    endfunction

    function automatic hit_t hi(input hit_t x, input hit_t y);
        return key_le(x, y) ? y : x;
    endfunction

    // Stage enables: a stage loads when empty or when its successor moves
    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // Comparator layers 1 to 3
    always_comb begin
        hit_t [NUM_HITS-1:0] x1;
        hit_t [NUM_HITS-1:0] x2;
        x1[0] = lo(in_item.hit[0], in_item.hit[5]);
        x1[5] = hi(in_item.hit[0], in_item.hit[5]);
        x1[1] = lo(in_item.hit[1], in_item.hit[3]);
        x1[3] = hi(in_item.hit[1], in_item.hit[3]);
        x1[2] = lo(in_item.hit[2], in_item.hit[4]);
        x1[4] = hi(in_item.hit[2], in_item.hit[4]);
        x2[0] = x1[0];
        x2[5] = x1[5];
        x2[1] = lo(x1[1], x1[2]);
        x2[2] = hi(x1[1], x1[2]);
        x2[3] = lo(x1[3], x1[4]);
        x2[4] = hi(x1[3], x1[4]);
        a_next.bad    = in_item.bad;
        a_next.hit[1] = x2[1];
        a_next.hit[4] = x2[4];
        a_next.hit[0] = lo(x2[0], x2[3]);
        a_next.hit[3] = hi(x2[0], x2[3]);
        a_next.hit[2] = lo(x2[2], x2[5]);
        a_next.hit[5] = hi(x2[2], x2[5]);
    end

    // Comparator layers 4 and 5
    always_comb begin
        hit_t [NUM_HITS-1:0] y4;
        y4[0] = lo(a_item_reg.hit[0], a_item_reg.hit[1]);
        y4[1] = hi(a_item_reg.hit[0], a_item_reg.hit[1]);
        y4[2] = lo(a_item_reg.hit[2], a_item_reg.hit[3]);
        y4[3] = hi(a_item_reg.hit[2], a_item_reg.hit[3]);
        y4[4] = lo(a_item_reg.hit[4], a_item_reg.hit[5]);
        y4[5] = hi(a_item_reg.hit[4], a_item_reg.hit[5]);
        b_next.bad    = a_item_reg.bad;
        b_next.hit[0] = y4[0];
        b_next.hit[5] = y4[5];
        b_next.hit[1] = lo(y4[1], y4[2]);
        b_next.hit[2] = hi(y4[1], y4[2]);
        b_next.hit[3] = lo(y4[3], y4[4]);
        b_next.hit[4] = hi(y4[3], y4[4]);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (en_a) begin
                a_valid_reg <= in_valid;
            end
            if (en_b) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en_a && in_valid) begin
            a_item_reg <= a_next;
        end
        if (en_b && a_valid_reg) begin
            b_item_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    `VTPID_ASSERT_CLK(sort_ordered, b_valid_reg |-> (key_le(b_item_reg.hit[0], b_item_reg.hit[1]) && key_le(b_item_reg.hit[1], b_item_reg.hit[2]) && key_le(b_item_reg.hit[2], b_item_reg.hit[3]) && key_le(b_item_reg.hit[3], b_item_reg.hit[4]) && key_le(b_item_reg.hit[4], b_item_reg.hit[5])), "sorter output out of order")
    `VTPID_ASSERT_CLK(sort_fill, in_valid && in_ready |=> a_valid_reg, "accepted request not held in first stage")
    `VTPID_ASSERT_CLK(sort_ready, !b_valid_reg |-> in_ready, "sorter stalls with empty last stage")

endmodule

// File: rtl/core/voxel_track_pattern_id_top.sv
// Throughput: one request per cycle while m_tready is high; five register stages (input decode,
// two sorting-network stages, offset coding, output register), each with a valid bit.
// A stage takes new data whenever it is empty or its successor moves.
// Reset (aresetn low, synchronous) clears all stage valid bits; no other state.
// ----------------------------------------------------------------------------
// voxel_track_pattern_id_top
// Sorts up to six voxel hits and forms the ten-letter track pattern id.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module voxel_track_pattern_id_top import vtpid_pkg::*; #(
    parameter int CUBE_SIZE = CUBE_SIZE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // hit_count[2:0], hit_0 .. hit_5 (8 bits each), zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // id_valid[0], id_char_0 .. id_char_9 (7 bits each), zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam dec_tbl_t    DEC_TBL = decomp_table(CUBE_SIZE);
    localparam logic [9:0]  VOLUME  = 10'(CUBE_SIZE * CUBE_SIZE * CUBE_SIZE);

    // Per-hit coding result after the vertex is known
    typedef struct packed {
        logic               counted;
        logic [COORD_W-1:0] rel;
        logic [CODE_W-1:0]  row_code;
        logic [CODE_W-1:0]  col_code;
    } hit_code_t;

    typedef struct packed {
        logic                       bad;
        hit_code_t [NUM_HITS-1:1]   hc;
    } code_item_t;

    logic                 s1_valid_reg;
    sort_item_t           s1_item_reg;
    sort_item_t           s1_next;
    logic                 en1;
    logic                 sort_in_ready;
    logic                 sort_out_valid;
    sort_item_t           sort_out_item;
    logic                 s4_valid_reg;
    code_item_t           s4_item_reg;
    code_item_t           s4_next;
    logic                 en4;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic                 en5;
    logic                 chars_ok;

    // Stage enables
    assign en5      = !m_valid_reg || m_tready;
    assign en4      = !s4_valid_reg || en5;
    assign en1      = !s1_valid_reg || sort_in_ready;
    assign s_tready = en1;

    // Stage 1: count checks, range checks and decomposition by table
    always_comb begin
        logic [COUNT_W-1:0] cnt;
        logic [COPY_W-1:0]  copy;
        logic               bad;
        cnt = s_tdata[COUNT_W-1:0];
        bad = (cnt < MIN_HITS) || (cnt > MAX_HITS);
        for (int n = 0; n < NUM_HITS; n++) begin
            copy = s_tdata[COUNT_W + n*COPY_W +: COPY_W];
            s1_next.hit[n].beyond = (cnt <= COUNT_W'(n));
            s1_next.hit[n].copy   = copy;
            {s1_next.hit[n].layer, s1_next.hit[n].row, s1_next.hit[n].col} = DEC_TBL[copy];
            if (!s1_next.hit[n].beyond && ({2'b00, copy} >= VOLUME)) begin
                bad = 1'b1;
            end
        end
        s1_next.bad = bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en1) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            s1_item_reg <= s1_next;
        end
    end

    // Stages 2 and 3: sorting network
    vtpid_sort6 u_sort (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ready  (sort_in_ready),
        .in_item   (s1_item_reg),
        .out_valid (sort_out_valid),
        .out_ready (en4),
        .out_item  (sort_out_item)
    );

    // Stage 4: relative layer, offset codes, shared-layer check
    always_comb begin
        logic shared;
        shared = 1'b0;
        for (int n = 1; n < NUM_HITS; n++) begin
            s4_next.hc[n].counted  = !sort_out_item.hit[n].beyond;
            s4_next.hc[n].rel      = sort_out_item.hit[n].layer - sort_out_item.hit[0].layer;
            s4_next.hc[n].row_code = offset_code(sort_out_item.hit[n].row,
                                                 sort_out_item.hit[0].row);
            s4_next.hc[n].col_code = offset_code(sort_out_item.hit[n].col,
                                                 sort_out_item.hit[0].col);
            // sorted, so equal layers sit next to each other
            if (!sort_out_item.hit[n].beyond &&
                (sort_out_item.hit[n].layer == sort_out_item.hit[n-1].layer)) begin
                shared = 1'b1;
            end
        end
        s4_next.bad = sort_out_item.bad || shared;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en4) begin
            s4_valid_reg <= sort_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4 && sort_out_valid) begin
            s4_item_reg <= s4_next;
        end
    end

    // Stage 5: place codes by relative layer, convert to letters
    always_comb begin
        logic [CODE_W-1:0] col_c;
        logic [CODE_W-1:0] row_c;
        int                layer;
        m_tdata_next    = '0;
        m_tdata_next[0] = !s4_item_reg.bad;
        for (int i = 0; i < OUT_LAYERS; i++) begin
            layer = OUT_LAYERS - i;
            col_c = EMPTY_CODE;
            row_c = EMPTY_CODE;
            for (int n = 1; n < NUM_HITS; n++) begin
                if (s4_item_reg.hc[n].counted && (s4_item_reg.hc[n].rel == COORD_W'(layer))) begin
                    col_c = s4_item_reg.hc[n].col_code;
                    row_c = s4_item_reg.hc[n].row_code;
                end
            end
            if (!s4_item_reg.bad) begin
                m_tdata_next[1 + 2*i*CHAR_W +: CHAR_W]      = CHAR_W'(col_c) + ASCII_BASE;
                m_tdata_next[1 + (2*i+1)*CHAR_W +: CHAR_W]  = CHAR_W'(row_c) + ASCII_BASE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en5) begin
            m_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5 && s4_valid_reg) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // Letter range of a formed id
    always_comb begin
        logic [CHAR_W-1:0] ch;
        chars_ok = 1'b1;
        for (int k = 0; k < 2*OUT_LAYERS; k++) begin
            ch = m_tdata_reg[1 + k*CHAR_W +: CHAR_W];
            if ((ch < ASCII_BASE) || (ch > ASCII_LAST)) begin
                chars_ok = 1'b0;
            end
        end
    end

    `VTPID_ASSERT_CLK(id_letters, m_valid_reg && m_tdata_reg[0] |-> chars_ok, "formed id has a letter out of range")
    `VTPID_ASSERT_CLK(id_empty, m_valid_reg && !m_tdata_reg[0] |-> (m_tdata_reg == '0), "empty result carries letters")
    `VTPID_ASSERT_CLK(two_hits, s4_valid_reg && !s4_item_reg.bad |-> s4_item_reg.hc[1].counted, "id formed from fewer than two hits")
    `VTPID_ASSERT_RST(reset_idle, !aresetn |=> !m_valid_reg && !s4_valid_reg && !s1_valid_reg, "valid bit survives reset")

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the voxel track pattern id core. A table of directed
// events comes first, then random events, mostly well-formed tracks, some with
// one defect, some plain noise. Each accepted request gets its pattern id
// predicted here. Results are compared in order against that prediction. The
// bench runs three idle mixes and one long sink stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import vtpid_pkg::*; ();

    localparam int CUBE            = CUBE_SIZE_DEF;
    localparam int PLANE           = CUBE * CUBE;
    localparam int VOLUME          = PLANE * CUBE;
    localparam int VOID_CODE       = 23;
    localparam int NEG_OFFSET      = 10;
    localparam int LETTER_A        = 97;
    localparam int REL_LAYERS      = 8;
    localparam int ITEMS_PER_PHASE = 430;
    localparam int SINK_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 100000;

    // Request and result, laid out as on the stream buses
    typedef struct packed {
        logic [NUM_HITS-1:0][COPY_W-1:0] hit;
        logic [COUNT_W-1:0]              count;
    } event_req_t;

    typedef struct packed {
        logic [2*OUT_LAYERS-1:0][CHAR_W-1:0] ch;
        logic                                id_valid;
    } pattern_id_t;

    typedef struct {
        event_req_t  req;
        bit          typed;
        pattern_id_t id;
    } dir_row_t;

    typedef enum int {PH_RESET, PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FULL_RATE} phase_t;
    typedef enum int {EV_CLEAN, EV_BROKEN, EV_NOISE} event_kind_t;
    typedef enum int {FLAW_LAYER, FLAW_RANGE, FLAW_COUNT} flaw_t;

    localparam pattern_id_t NO_ID = '0;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    phase_t      stim_phase;
    pattern_id_t expected_ids[$];
    dir_row_t    dir_rows[$];
    int          mismatch_cnt;
    int          cycle_cnt;

    voxel_track_pattern_id_top #(
        .CUBE_SIZE(CUBE)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Append one id to the in-order list of expected results
    function automatic void log_expected(input pattern_id_t id);
        expected_ids.insert(expected_ids.size(), id);
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input event_req_t req, input bit typed,
                                    input pattern_id_t id);
        dir_row_t row;
        row.req   = req;
        row.typed = typed;
        row.id    = id;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Offset of one coordinate from the vertex: plain, or magnitude + 10 if negative
    function automatic int code_offset(input int v, input int vtx);
        return (v >= vtx) ? (v - vtx) : (vtx - v + NEG_OFFSET);
    endfunction

    // Pattern id of one event
    function automatic pattern_id_t predict_pattern_id(input event_req_t req);
        pattern_id_t res;
        int          n;
        int          h[NUM_HITS];
        int          row_code[REL_LAYERS];
        int          col_code[REL_LAYERS];
        bit          taken[REL_LAYERS];
        int          i;
        int          j;
        int          t;
        int          l0;
        int          r0;
        int          c0;
        int          rel;
        res = NO_ID;
        n = req.count;
        if (n < 2 || n > NUM_HITS) begin
            return res;
        end
        for (i = 0; i < n; i++) begin
            h[i] = req.hit[i];
            if (h[i] >= VOLUME) begin
                return res;
            end
        end
        // ascending order, vertex first
        for (i = 0; i < n - 1; i++) begin
            for (j = 0; j < n - 1 - i; j++) begin
                if (h[j] > h[j+1]) begin
                    t = h[j];
                    h[j] = h[j+1];
                    h[j+1] = t;
                end
            end
        end
        for (i = 0; i < REL_LAYERS; i++) begin
            row_code[i] = VOID_CODE;
            col_code[i] = VOID_CODE;
            taken[i] = 1'b0;
        end
        l0 = h[0] / PLANE;
        r0 = (h[0] / CUBE) % CUBE;
        c0 = h[0] % CUBE;
        for (i = 1; i < n; i++) begin
            rel = h[i] / PLANE - l0;
            if (rel < 0) begin
                rel = -rel;
            end
            if (rel == 0 || rel >= REL_LAYERS || taken[rel]) begin
                return res;
            end
            taken[rel] = 1'b1;
            row_code[rel] = code_offset((h[i] / CUBE) % CUBE, r0);
            col_code[rel] = code_offset(h[i] % CUBE, c0);
        end
        res.id_valid = 1'b1;
        // letters run from relative layer 5 down to 1, column before row
        for (i = 0; i < OUT_LAYERS; i++) begin
            res.ch[2*i]   = CHAR_W'(col_code[OUT_LAYERS-i] + LETTER_A);
            res.ch[2*i+1] = CHAR_W'(row_code[OUT_LAYERS-i] + LETTER_A);
        end
        return res;
    endfunction

    function automatic event_req_t mk_req(input int n, input int h0, input int h1,
                                          input int h2, input int h3, input int h4,
                                          input int h5);
        event_req_t req;
        req.count  = COUNT_W'(n);
        req.hit[0] = COPY_W'(h0);
        req.hit[1] = COPY_W'(h1);
        req.hit[2] = COPY_W'(h2);
        req.hit[3] = COPY_W'(h3);
        req.hit[4] = COPY_W'(h4);
        req.hit[5] = COPY_W'(h5);
        return req;
    endfunction

    // Valid id spelled as its ten letters
    function automatic pattern_id_t letters_id(input string s);
        pattern_id_t id;
        int          i;
        id.id_valid = 1'b1;
        for (i = 0; i < 2 * OUT_LAYERS; i++) begin
            id.ch[i] = CHAR_W'(s[i]);
        end
        return id;
    endfunction

    // Track with one hit per distinct layer, random rows, columns and order
    function automatic event_req_t make_clean();
        event_req_t req;
        int         pool[CUBE];
        int         i;
        int         j;
        int         t;
        int         n;
        for (i = 0; i < CUBE; i++) begin
            pool[i] = i;
        end
        for (i = CUBE - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        n = $urandom_range(2, NUM_HITS);
        req.count = COUNT_W'(n);
        for (i = 0; i < NUM_HITS; i++) begin
            if (i < n) begin
                req.hit[i] = COPY_W'(pool[i] * PLANE + $urandom_range(0, CUBE - 1) * CUBE
                                     + $urandom_range(0, CUBE - 1));
            end else begin
                req.hit[i] = COPY_W'($urandom_range(0, 255));
            end
        end
        return req;
    endfunction

    function automatic event_req_t make_event(input event_kind_t kind);
        event_req_t req;
        flaw_t      flaw;
        int         n;
        int         i;
        int         j;
        int         k;
        case (kind)
            EV_CLEAN: begin
                req = make_clean();
            end
            EV_BROKEN: begin
                req = make_clean();
                n = req.count;
                flaw = flaw_t'($urandom_range(0, 2));
                case (flaw)
                    FLAW_LAYER: begin
                        // move one hit into the layer of another
                        i = $urandom_range(0, n - 1);
                        j = (i + $urandom_range(1, n - 1)) % n;
                        req.hit[i] = COPY_W'((req.hit[j] / PLANE) * PLANE
                                             + $urandom_range(0, PLANE - 1));
                    end
                    FLAW_RANGE: begin
                        req.hit[$urandom_range(0, n - 1)] = COPY_W'($urandom_range(VOLUME, 255));
                    end
                    default: begin
                        k = $urandom_range(0, 2);
                        req.count = (k == 2) ? COUNT_W'(7) : COUNT_W'(k);
                    end
                endcase
            end
            default: begin
                req.count = COUNT_W'($urandom_range(0, 7));
                for (i = 0; i < NUM_HITS; i++) begin
                    req.hit[i] = COPY_W'($urandom_range(0, 255));
                end
            end
        endcase
        return req;
    endfunction

    // Offer one request, hold it until accepted, then log its expected id
    task automatic drive_request(input event_req_t req, input pattern_id_t id);
        int idle_pct;
        idle_pct = (stim_phase == PH_SLOW_SINK) ? 19 :
                   (stim_phase == PH_SLOW_SOURCE) ? 79 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(req);
        do @(posedge aclk); while (!s_tready);
        log_expected(id);
        @(negedge aclk);
    endtask

    // Sink side: random ready, one long hold-off when full rate starts
    initial begin : sink_drive
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stim_phase == PH_FULL_RATE && !hold_done) begin
                hold_left = SINK_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= ((stim_phase == PH_SLOW_SINK) ? 79 :
                             (stim_phase == PH_SLOW_SOURCE) ? 19 : 0));
            end
        end
    end

    // Result check against the oldest expected id
    always @(posedge aclk) begin : result_check
        pattern_id_t exp_id;
        pattern_id_t got_id;
        int          i;
        if (aresetn && m_tvalid && m_tready) begin
            got_id = pattern_id_t'(m_tdata[M_FIELDS_W-1:0]);
            if (expected_ids.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatch_cnt++;
            end else begin
                exp_id = expected_ids.pop_front();
                if (got_id.id_valid !== exp_id.id_valid) begin
                    $display("%0t: id_valid expected %0b actual %0b", $time,
                             exp_id.id_valid, got_id.id_valid);
                    mismatch_cnt++;
                end
                for (i = 0; i < 2 * OUT_LAYERS; i++) begin
                    if (got_id.ch[i] !== exp_id.ch[i]) begin
                        $display("%0t: id_char_%0d expected %0d actual %0d", $time, i,
                                 exp_id.ch[i], got_id.ch[i]);
                        mismatch_cnt++;
                    end
                end
                if (m_tdata[M_TDATA_W-1:M_FIELDS_W] !== '0) begin
                    $display("%0t: tdata pad expected 0 actual %h", $time,
                             m_tdata[M_TDATA_W-1:M_FIELDS_W]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("tb failed");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        event_req_t  req;
        int          i;
        int          r;
        event_kind_t kind;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        stim_phase = PH_RESET;
        mismatch_cnt = 0;

        // count out of range, cube bounds, vertex and shared layers, offset extremes
        add_row(mk_req(0, 0, 0, 0, 0, 0, 0), 1'b1, NO_ID);
        add_row(mk_req(1, 215, 0, 0, 0, 0, 0), 1'b1, NO_ID);
        add_row(mk_req(7, 0, 36, 72, 108, 144, 180), 1'b1, NO_ID);
        add_row(mk_req(2, 0, 36, 0, 0, 0, 0), 1'b1, letters_id("xxxxxxxxaa"));
        add_row(mk_req(2, 36, 0, 255, 255, 255, 255), 1'b1, letters_id("xxxxxxxxaa"));
        add_row(mk_req(2, 0, 216, 0, 0, 0, 0), 1'b1, NO_ID);
        add_row(mk_req(6, 0, 36, 72, 108, 144, 255), 1'b1, NO_ID);
        add_row(mk_req(3, 0, 5, 40, 0, 0, 0), 1'b1, NO_ID);
        add_row(mk_req(3, 0, 40, 41, 0, 0, 0), 1'b1, NO_ID);
        add_row(mk_req(6, 180, 144, 108, 72, 36, 0), 1'b1, letters_id("aaaaaaaaaa"));
        add_row(mk_req(6, 35, 36, 72, 108, 144, 180), 1'b0, NO_ID);
        add_row(mk_req(6, 0, 71, 107, 143, 179, 215), 1'b0, NO_ID);
        add_row(mk_req(4, 197, 107, 36, 14, 0, 0), 1'b0, NO_ID);
        add_row(mk_req(3, 215, 214, 0, 0, 0, 0), 1'b1, NO_ID);
        add_row(mk_req(5, 35, 215, 144, 108, 72, 0), 1'b0, NO_ID);
        add_row(mk_req(2, 255, 255, 0, 0, 0, 0), 1'b1, NO_ID);
        add_row(mk_req(3, 0, 36, 240, 0, 0, 0), 1'b1, NO_ID);

        // synchronous reset
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        stim_phase <= PH_SLOW_SINK;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            drive_request(dir_rows[i].req,
                          dir_rows[i].typed ? dir_rows[i].id
                                            : predict_pattern_id(dir_rows[i].req));
        end

        // random part under three idle mixes
        for (i = 0; i < 3 * ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE) begin
                stim_phase <= PH_SLOW_SOURCE;
            end else if (i == 2 * ITEMS_PER_PHASE) begin
                stim_phase <= PH_FULL_RATE;
            end
            r = $urandom_range(0, 99);
            kind = (r < 80) ? EV_CLEAN : (r < 90) ? EV_BROKEN : EV_NOISE;
            req = make_event(kind);
            drive_request(req, predict_pattern_id(req));
        end
        s_tvalid <= 1'b0;

        // drain
        while (expected_ids.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
